// ----- rtl/lbap_pkg.sv -----
// lbap_pkg: shared types and constants for the led/buzzer alert pattern block
// transaction payload structs, level codes and configuration register map
// no dependencies
package lbap_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned RegW     = 16;
  localparam int unsigned NowW     = 32;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_MONITOR = 2'd1,
    LVL_ALERT   = 2'd2
  } level_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_MON_BLINK_ON  = 3'd0,
    REG_MON_BLINK_OFF = 3'd1,
    REG_MON_BEEP_ON   = 3'd2,
    REG_MON_BEEP_GAP  = 3'd3,
    REG_ALT_BLINK_ON  = 3'd4,
    REG_ALT_BLINK_OFF = 3'd5,
    REG_ALT_BEEP_ON   = 3'd6,
    REG_ALT_BEEP_OFF  = 3'd7
  } reg_idx_e;

  typedef logic [RegW-1:0] reg_val_t;

  localparam reg_val_t RegReset [NumRegs] = '{
    16'd500, 16'd1500, 16'd100, 16'd5000, 16'd100, 16'd100, 16'd150, 16'd150
  };

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_SET    = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [1:0]      new_level;
    logic [NowW-1:0] now_ms;
  } lbap_in_t;

  typedef struct packed {
    logic       led_out;
    logic       buzzer_out;
    logic [1:0] level_now;
  } lbap_out_t;

endpackage

// ----- rtl/lbap_core.sv -----
// lbap_core: configuration registers, pattern state and per-transaction update
// depends on lbap_pkg
module lbap_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_wdata_i,
  input  logic                   push_i,
  input  lbap_pkg::lbap_in_t     in_data_i,
  output lbap_pkg::lbap_out_t    res_o
);
  import lbap_pkg::*;

  typedef logic [TIME_WIDTH-1:0] tm_t;

  reg_val_t cfg_q [NumRegs];

  level_e level_q, level_d;
  logic   led_q, led_d;
  logic   buz_q, buz_d;
  logic   gap_q, gap_d;
  tm_t    led_stamp_q, led_stamp_d;
  tm_t    buz_stamp_q, buz_stamp_d;

  tm_t now_t;
  tm_t led_el, buz_el;
  tm_t led_per, buz_per;

  if (TIME_WIDTH >= NowW) begin : g_now_wide
    assign now_t = {{(TIME_WIDTH - NowW){1'b0}}, in_data_i.now_ms};
  end else begin : g_now_narrow
    assign now_t = in_data_i.now_ms[TIME_WIDTH-1:0];
  end

  function automatic tm_t ext(input reg_val_t v);
    ext = {{(TIME_WIDTH - RegW){1'b0}}, v};
  endfunction

  assign led_el = now_t - led_stamp_q;
  assign buz_el = now_t - buz_stamp_q;

  always_comb begin
    if (level_q == LVL_ALERT) begin
      led_per = led_q ? ext(cfg_q[REG_ALT_BLINK_ON]) : ext(cfg_q[REG_ALT_BLINK_OFF]);
      buz_per = buz_q ? ext(cfg_q[REG_ALT_BEEP_ON]) : ext(cfg_q[REG_ALT_BEEP_OFF]);
    end else begin
      led_per = led_q ? ext(cfg_q[REG_MON_BLINK_ON]) : ext(cfg_q[REG_MON_BLINK_OFF]);
      buz_per = buz_q ? ext(cfg_q[REG_MON_BEEP_ON]) : ext(cfg_q[REG_MON_BEEP_GAP]);
    end
  end

  always_comb begin
    level_d     = level_q;
    led_d       = led_q;
    buz_d       = buz_q;
    gap_d       = gap_q;
    led_stamp_d = led_stamp_q;
    buz_stamp_d = buz_stamp_q;
    if (in_data_i.mode == MODE_SET) begin
      if (in_data_i.new_level != 2'd3 && in_data_i.new_level != level_q) begin
        level_d     = level_e'(in_data_i.new_level);
        led_stamp_d = '0;
        buz_stamp_d = '0;
        gap_d       = 1'b0;
        if (in_data_i.new_level == LVL_NORMAL) begin
          led_d = 1'b0;
          buz_d = 1'b0;
        end
      end
    end else begin
      unique case (level_q)
        LVL_MONITOR, LVL_ALERT: begin
          if (led_el >= led_per) begin
            led_stamp_d = now_t;
            led_d       = ~led_q;
          end
          if (level_q == LVL_ALERT) begin
            if (buz_el >= buz_per) begin
              buz_stamp_d = now_t;
              buz_d       = ~buz_q;
            end
          end else if (!buz_q && !gap_q) begin
            buz_d       = 1'b1;
            buz_stamp_d = now_t;
          end else if (buz_el >= buz_per) begin
            buz_stamp_d = now_t;
            buz_d       = 1'b0;
            gap_d       = buz_q;
          end
        end
        default: begin
          led_d = 1'b0;
          buz_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= RegReset[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LVL_NORMAL;
      led_q       <= 1'b0;
      buz_q       <= 1'b0;
      gap_q       <= 1'b0;
      led_stamp_q <= '0;
      buz_stamp_q <= '0;
    end else if (push_i) begin
      level_q     <= level_d;
      led_q       <= led_d;
      buz_q       <= buz_d;
      gap_q       <= gap_d;
      led_stamp_q <= led_stamp_d;
      buz_stamp_q <= buz_stamp_d;
    end
  end

  assign res_o.led_out    = led_d;
  assign res_o.buzzer_out = buz_d;
  assign res_o.level_now  = level_d;

endmodule

// ----- rtl/lbap_skid.sv -----
// lbap_skid: result register with a skid stage on the output channel
// depends on lbap_pkg
module lbap_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lbap_pkg::lbap_out_t data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbap_pkg::lbap_out_t out_data_o
);
  import lbap_pkg::*;

  logic      main_vld_q, main_vld_d;
  logic      skid_vld_q, skid_vld_d;
  lbap_out_t main_q, main_d;
  lbap_out_t skid_q, skid_d;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (!main_vld_q || !out_stall_i) begin
      main_vld_d = skid_vld_q || push_i;
      main_d     = skid_vld_q ? skid_q : data_i;
      skid_vld_d = 1'b0;
    end else if (push_i) begin
      skid_vld_d = 1'b1;
      skid_d     = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule

// ----- rtl/led_buzzer_alert_pattern.sv -----
// Alert pattern generator for an LED and a buzzer. Each input transaction either sets the
// alert level (normal, monitor, alert) or applies an update at the given millisecond time;
// every transaction yields exactly one result with the LED, buzzer and level after its effect.
// One transaction is taken per clock: the level/stamp update is a single registered pass,
// and the result sits in an output register backed by a one-entry skid stage, so input
// stalls only when both are full. Timing registers are written through the plain write port;
// the user must write them only while the block is idle, which the block does not enforce.
// depends on lbap_pkg, lbap_core, lbap_skid
module led_buzzer_alert_pattern #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbap_pkg::lbap_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbap_pkg::lbap_out_t out_data_o
);
  import lbap_pkg::*;

  logic      push;
  logic      full;
  lbap_out_t res;

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  lbap_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .res_o      (res)
  );

  lbap_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for led_buzzer_alert_pattern, with a clocked driver and monitor
// items are predicted on acceptance and compared field by field with each result
// depends on lbap_pkg and the led_buzzer_alert_pattern rtl
module tb_top;
  import lbap_pkg::*;

  localparam logic [1:0] LvlUnused = 2'd3;
  localparam int unsigned CycLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned HoldAfter = 850;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  reg_idx_e  cfg_idx = REG_MON_BLINK_ON;
  reg_val_t  cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lbap_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lbap_out_t out_data;

  lbap_in_t  alert_items_q[$];
  lbap_out_t led_buzzer_due_q[$];

  reg_val_t    tmr [NumRegs];
  logic [1:0]  cur_lvl;
  logic        led_on;
  logic [31:0] led_t;
  logic        buz_on;
  logic [31:0] buz_t;
  logic        gap;

  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 52;
  int unsigned n_sent = 0;
  int unsigned n_err = 0;
  int unsigned cyc_cnt = 0;
  int unsigned hold_left = 0;
  logic        held = 1'b0;
  logic [31:0] clk_ms = '0;

  led_buzzer_alert_pattern dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] lapsed(input logic [31:0] now, input logic [31:0] stamp);
    return now - stamp;
  endfunction

  task automatic blink(input logic [31:0] now, input reg_val_t on_ms, input reg_val_t off_ms);
    if (lapsed(now, led_t) >= 32'(led_on ? on_ms : off_ms)) begin
      led_t = now;
      led_on = !led_on;
    end
  endtask

  task automatic advance_alert_pattern(input lbap_in_t it, output lbap_out_t res);
    logic [31:0] now;
    now = it.now_ms;
    if (it.mode == MODE_SET) begin
      if (it.new_level != LvlUnused && it.new_level != cur_lvl) begin
        cur_lvl = it.new_level;
        led_t = '0;
        buz_t = '0;
        gap = 1'b0;
        if (it.new_level == LVL_NORMAL) begin
          led_on = 1'b0;
          buz_on = 1'b0;
        end
      end
    end else begin
      case (cur_lvl)
        LVL_MONITOR: begin
          blink(now, tmr[REG_MON_BLINK_ON], tmr[REG_MON_BLINK_OFF]);
          if (!buz_on && !gap) begin
            buz_on = 1'b1;
            buz_t = now;
          end else if (buz_on) begin
            if (lapsed(now, buz_t) >= 32'(tmr[REG_MON_BEEP_ON])) begin
              buz_on = 1'b0;
              buz_t = now;
              gap = 1'b1;
            end
          end else if (lapsed(now, buz_t) >= 32'(tmr[REG_MON_BEEP_GAP])) begin
            gap = 1'b0;
            buz_t = now;
          end
        end
        LVL_ALERT: begin
          blink(now, tmr[REG_ALT_BLINK_ON], tmr[REG_ALT_BLINK_OFF]);
          if (lapsed(now, buz_t) >=
              32'(buz_on ? tmr[REG_ALT_BEEP_ON] : tmr[REG_ALT_BEEP_OFF])) begin
            buz_t = now;
            buz_on = !buz_on;
          end
        end
        default: begin
          led_on = 1'b0;
          buz_on = 1'b0;
        end
      endcase
    end
    res.led_out = led_on;
    res.buzzer_out = buz_on;
    res.level_now = cur_lvl;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lbap_out_t res;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_alert_pattern(in_data, res);
        led_buzzer_due_q.push_back(res);
        n_sent <= n_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (alert_items_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= alert_items_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      held <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && n_sent >= HoldAfter) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
      held <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lbap_out_t due;
    if (rst_ni && out_valid && !out_stall) begin
      if (led_buzzer_due_q.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %h", $time, out_data);
        n_err++;
      end else begin
        due = led_buzzer_due_q.pop_front();
        if (out_data.led_out !== due.led_out) begin
          $display("%0t led_out mismatch: expected %0b, actual %0b",
                   $time, due.led_out, out_data.led_out);
          n_err++;
        end
        if (out_data.buzzer_out !== due.buzzer_out) begin
          $display("%0t buzzer_out mismatch: expected %0b, actual %0b",
                   $time, due.buzzer_out, out_data.buzzer_out);
          n_err++;
        end
        if (out_data.level_now !== due.level_now) begin
          $display("%0t level_now mismatch: expected %0d, actual %0d",
                   $time, due.level_now, out_data.level_now);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CycLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_update(input logic [31:0] t, input logic [1:0] lvl_bits);
    lbap_in_t it;
    it.mode = MODE_UPDATE;
    it.new_level = lvl_bits;
    it.now_ms = t;
    alert_items_q.push_back(it);
  endtask

  task automatic push_set(input logic [1:0] lvl, input logic [31:0] t);
    lbap_in_t it;
    it.mode = MODE_SET;
    it.new_level = lvl;
    it.now_ms = t;
    alert_items_q.push_back(it);
  endtask

  task automatic gen_random(input int unsigned n, input int unsigned step_max);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        clk_ms = $urandom;
      end else if (r < 4) begin
        clk_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end
      if (r >= 4 && r < 16) begin
        push_set(($urandom_range(0, 9) == 0) ? LvlUnused : 2'($urandom_range(0, 2)), $urandom);
      end else begin
        clk_ms = clk_ms + $urandom_range(0, step_max);
        push_update(clk_ms, 2'($urandom_range(0, 3)));
      end
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input reg_val_t v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    tmr[idx] = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input reg_val_t mb_on, input reg_val_t mb_off,
                           input reg_val_t mp_on, input reg_val_t mp_gap,
                           input reg_val_t ab_on, input reg_val_t ab_off,
                           input reg_val_t ap_on, input reg_val_t ap_off);
    write_reg(REG_MON_BLINK_ON, mb_on);
    write_reg(REG_MON_BLINK_OFF, mb_off);
    write_reg(REG_MON_BEEP_ON, mp_on);
    write_reg(REG_MON_BEEP_GAP, mp_gap);
    write_reg(REG_ALT_BLINK_ON, ab_on);
    write_reg(REG_ALT_BLINK_OFF, ab_off);
    write_reg(REG_ALT_BEEP_ON, ap_on);
    write_reg(REG_ALT_BEEP_OFF, ap_off);
  endtask

  task automatic drain();
    while (alert_items_q.size() != 0 || in_valid || led_buzzer_due_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) tmr[i] = RegReset[i];
    cur_lvl = LVL_NORMAL;
    led_on = 1'b0;
    led_t = '0;
    buz_on = 1'b0;
    buz_t = '0;
    gap = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // beep, gap and re-arm at reset timings, then wrap and ignored requests
    push_update(32'd0, LVL_MONITOR);
    push_set(LVL_MONITOR, 32'hFFFF_FFFF);
    push_update(32'd0, LvlUnused);
    push_update(32'd99, LVL_NORMAL);
    push_update(32'd100, LVL_ALERT);
    push_update(32'd1500, LVL_NORMAL);
    push_update(32'd2000, LVL_NORMAL);
    push_update(32'd5100, LVL_NORMAL);
    push_update(32'd5101, LVL_NORMAL);
    push_set(LVL_MONITOR, 32'd0);
    push_set(LvlUnused, 32'hFFFF_FFFF);
    push_update(32'd5300, LVL_NORMAL);
    push_set(LVL_ALERT, 32'd0);
    push_update(32'hFFFF_FFFF, LvlUnused);
    push_update(32'd149, LVL_NORMAL);
    push_update(32'd300, LVL_NORMAL);
    push_update(32'd450, LVL_NORMAL);
    push_set(LVL_NORMAL, 32'h5555_AAAA);
    push_update(32'hAAAA_5555, LVL_ALERT);
    push_set(LVL_ALERT, 32'd0);
    push_set(LVL_MONITOR, 32'd0);
    push_update(32'h8000_0000, LVL_NORMAL);
    drain();

    clk_ms = '0;
    gen_random(200, 300);
    drain();

    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    gen_random(100, 3);
    drain();

    write_all('1, '1, '1, '1, '1, '1, '1, '1);
    gen_random(100, 20000);
    drain();

    tx_idle_pct = 52;
    rx_idle_pct = 15;
    write_all(reg_val_t'($urandom_range(0, 50)), reg_val_t'($urandom_range(0, 50)),
              reg_val_t'($urandom_range(0, 50)), reg_val_t'($urandom_range(0, 50)),
              reg_val_t'($urandom_range(0, 50)), reg_val_t'($urandom_range(0, 50)),
              reg_val_t'($urandom_range(0, 50)), reg_val_t'($urandom_range(0, 50)));
    gen_random(200, 40);
    drain();

    write_all(reg_val_t'($urandom), reg_val_t'($urandom), reg_val_t'($urandom),
              reg_val_t'($urandom), reg_val_t'($urandom), reg_val_t'($urandom),
              reg_val_t'($urandom), reg_val_t'($urandom));
    gen_random(150, 30000);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_all(16'd3, 16'd0, 16'd1, 16'd60, 16'd0, 16'd7, 16'd20, 16'd1);
    gen_random(200, 60);
    drain();

    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
